### design/rc_pkg.sv
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types and constants for the radix converter: request and response
// beats, radix and error codes, and the sizes of the binary-to-BCD unit.
// ----------------------------------------------------------------------------
package rc_pkg;

   // radix codes
   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_BIN  = 2'd1;
   localparam logic [1:0] ERR_OCT  = 2'd2;
   localparam logic [1:0] ERR_PAIR = 2'd3;

   // ascii
   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_ALPHA = 7'd55;
   localparam logic [3:0] DIGIT_TEN  = 4'd10;

   // binary-to-bcd unit: widest value is 32 bits, ten decimal digits
   localparam int CONV_BITS  = 32;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_BITS   = 4 * BCD_DIGITS;

   typedef struct packed {
      logic [1:0]  from_radix;
      logic [1:0]  to_radix;
      logic [30:0] number;
      logic [63:0] hex_text;
      logic [3:0]  hex_length;
   } req_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic [1:0] error_code;
      logic       last_digit_flag;
   } rsp_type;

endpackage

### design/radix_converter.sv
// ----------------------------------------------------------------------------
// radix_converter
// Converts one number per request between binary, octal, decimal and hex and
// returns the destination digits as ascii, most significant first.
// ----------------------------------------------------------------------------
//
//   channel   ports                      handshake
//   -------   ------------------------   -----------------------------------
//   request   start, busy, req_item      taken when start is high, busy low
//   response  rsp_strobe, rsp_item       one beat per digit, single cycle
//
// An equal source and destination radix returns its error beat in the cycle
// after the request and leaves busy low. Otherwise busy is high while the
// request is worked on: decimal-coded sources pass through the shared
// shift/add-3 unit and then take one decimal digit per cycle, hex sources one
// character per cycle, decimal destinations pass through the same unit again,
// and output takes one digit slot per cycle (VALUE_BITS slots for binary),
// leading zeros skipped. Reset is synchronous; the receiver cannot stall, so
// beats go out without waiting.
//
module radix_converter #(
   parameter int MAX_HEX_CHARS = 8,
   parameter int VALUE_BITS    = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rc_pkg::req_type req_item,
   output logic            rsp_strobe,
   output rc_pkg::rsp_type rsp_item
);
   import rc_pkg::*;

   localparam int CNT_W  = $clog2(BCD_BITS + 1);
   localparam int N_BIN  = VALUE_BITS;
   localparam int N_OCT  = (VALUE_BITS + 2) / 3;
   localparam int N_HEX  = (VALUE_BITS + 3) / 4;
   localparam int SH_BIN = BCD_BITS - N_BIN;
   localparam int SH_OCT = BCD_BITS - 3 * N_OCT;
   localparam int SH_HEX = BCD_BITS - 4 * N_HEX;

   localparam logic [7:0] ASC_0  = 8'h30;
   localparam logic [7:0] ASC_9  = 8'h39;
   localparam logic [7:0] ASC_UA = 8'h41;
   localparam logic [7:0] ASC_UF = 8'h46;
   localparam logic [7:0] ASC_LA = 8'h61;
   localparam logic [7:0] ASC_LF = 8'h66;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRC_CONV,
      S_SRC_DIGITS,
      S_HEX,
      S_PREP,
      S_OUT_CONV,
      S_EMIT
   } state_type;

   state_type             state_ff;
   logic [1:0]            from_ff;
   logic [1:0]            to_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [63:0]           text_ff;
   logic [3:0]            len_ff;
   logic [BCD_BITS-1:0]   shreg_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  started_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   logic                  accept;
   logic                  conv_go;
   logic [CONV_BITS-1:0]  conv_value;
   logic                  conv_done;
   logic [BCD_BITS-1:0]   conv_bcd;
   logic [3:0]            src_digit;
   logic                  src_bad;
   logic [VALUE_BITS-1:0] acc_in;
   logic [3:0]            hex_digit;
   logic [VALUE_BITS-1:0] hex_in;
   logic [3:0]            emit_digit;
   logic                  emit_now;
   logic [6:0]            emit_char;
   logic [BCD_BITS-1:0]   shreg_in;
   logic [3:0]            len_sat;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c >= ASC_0 && c <= ASC_9) begin
         d = c[3:0];
      end else if ((c >= ASC_UA && c <= ASC_UF) || (c >= ASC_LA && c <= ASC_LF)) begin
         // letters sit at 1..6 in the low nibble
         d = c[3:0] + 4'd9;
      end
      return d;
   endfunction

   rc_bcd_unit u_bcd (
      .clock      (clock),
      .reset      (reset),
      .conv_go    (conv_go),
      .conv_value (conv_value),
      .conv_done  (conv_done),
      .conv_bcd   (conv_bcd)
   );

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      len_sat = (req_item.hex_length > 4'(MAX_HEX_CHARS)) ? 4'(MAX_HEX_CHARS)
                                                          : req_item.hex_length;

      conv_go = (accept && (req_item.from_radix != req_item.to_radix)
                 && (req_item.from_radix == RADIX_BIN || req_item.from_radix == RADIX_OCT))
                || (state_ff == S_PREP && to_ff == RADIX_DEC);
      conv_value = (state_ff == S_IDLE) ? CONV_BITS'(req_item.number)
                                        : CONV_BITS'(val_ff);

      // source digits, most significant first
      src_digit = shreg_ff[BCD_BITS-1 -: 4];
      if (from_ff == RADIX_BIN) begin
         src_bad = src_digit > 4'd1;
         acc_in  = (val_ff << 1) + VALUE_BITS'(src_digit);
      end else begin
         src_bad = src_digit > 4'd7;
         acc_in  = (val_ff << 3) + VALUE_BITS'(src_digit);
      end

      hex_digit = hex_value(text_ff[63:56]);
      hex_in    = (val_ff << 4) + VALUE_BITS'(hex_digit);

      case (to_ff)
         RADIX_BIN: begin
            emit_digit = {3'b000, shreg_ff[BCD_BITS-1]};
            shreg_in   = shreg_ff << 1;
         end
         RADIX_OCT: begin
            emit_digit = {1'b0, shreg_ff[BCD_BITS-1 -: 3]};
            shreg_in   = shreg_ff << 3;
         end
         default: begin
            emit_digit = shreg_ff[BCD_BITS-1 -: 4];
            shreg_in   = shreg_ff << 4;
         end
      endcase

      // leading zeros are skipped, but the last slot always goes out
      emit_now  = started_ff || (emit_digit != 4'd0) || (cnt_ff == CNT_W'(1));
      emit_char = (emit_digit < DIGIT_TEN) ? CHAR_ZERO + 7'(emit_digit)
                                           : CHAR_ALPHA + 7'(emit_digit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         started_ff    <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  from_ff <= req_item.from_radix;
                  to_ff   <= req_item.to_radix;
                  text_ff <= req_item.hex_text;
                  len_ff  <= len_sat;
                  val_ff  <= '0;
                  if (req_item.from_radix == req_item.to_radix) begin
                     rsp_strobe_ff          <= 1'b1;
                     rsp_ff.digit_char      <= '0;
                     rsp_ff.error_code      <= ERR_PAIR;
                     rsp_ff.last_digit_flag <= 1'b1;
                  end else begin
                     unique case (req_item.from_radix) inside
                        RADIX_BIN, RADIX_OCT: state_ff <= S_SRC_CONV;
                        RADIX_DEC: begin
                           val_ff   <= VALUE_BITS'(req_item.number);
                           state_ff <= S_PREP;
                        end
                        default: state_ff <= S_HEX;
                     endcase
                  end
               end
            end
            S_SRC_CONV: begin
               if (conv_done) begin
                  shreg_ff <= conv_bcd;
                  cnt_ff   <= CNT_W'(BCD_DIGITS);
                  state_ff <= S_SRC_DIGITS;
               end
            end
            S_SRC_DIGITS: begin
               if (src_bad) begin
                  rsp_strobe_ff          <= 1'b1;
                  rsp_ff.digit_char      <= '0;
                  rsp_ff.error_code      <= (from_ff == RADIX_BIN) ? ERR_BIN : ERR_OCT;
                  rsp_ff.last_digit_flag <= 1'b1;
                  state_ff               <= S_IDLE;
               end else begin
                  val_ff   <= acc_in;
                  shreg_ff <= shreg_ff << 4;
                  cnt_ff   <= cnt_ff - 1'b1;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_ff <= S_PREP;
                  end
               end
            end
            S_HEX: begin
               if (len_ff == 4'd0) begin
                  state_ff <= S_PREP;
               end else begin
                  val_ff  <= hex_in;
                  text_ff <= text_ff << 8;
                  len_ff  <= len_ff - 1'b1;
               end
            end
            S_PREP: begin
               started_ff <= 1'b0;
               unique case (to_ff)
                  RADIX_BIN: begin
                     shreg_ff <= BCD_BITS'(val_ff) << SH_BIN;
                     cnt_ff   <= CNT_W'(N_BIN);
                     state_ff <= S_EMIT;
                  end
                  RADIX_OCT: begin
                     shreg_ff <= BCD_BITS'(val_ff) << SH_OCT;
                     cnt_ff   <= CNT_W'(N_OCT);
                     state_ff <= S_EMIT;
                  end
                  RADIX_HEX: begin
                     shreg_ff <= BCD_BITS'(val_ff) << SH_HEX;
                     cnt_ff   <= CNT_W'(N_HEX);
                     state_ff <= S_EMIT;
                  end
                  default: state_ff <= S_OUT_CONV;
               endcase
            end
            S_OUT_CONV: begin
               if (conv_done) begin
                  shreg_ff <= conv_bcd;
                  cnt_ff   <= CNT_W'(BCD_DIGITS);
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_now) begin
                  rsp_strobe_ff          <= 1'b1;
                  rsp_ff.digit_char      <= emit_char;
                  rsp_ff.error_code      <= ERR_NONE;
                  rsp_ff.last_digit_flag <= (cnt_ff == CNT_W'(1));
                  started_ff             <= 1'b1;
               end
               shreg_ff <= shreg_in;
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### design/rc_bcd_unit.sv
// ----------------------------------------------------------------------------
// rc_bcd_unit
// Iterative binary-to-BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module rc_bcd_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          conv_go,
   input  logic [rc_pkg::CONV_BITS-1:0]  conv_value,
   output logic                          conv_done,
   output logic [rc_pkg::BCD_BITS-1:0]   conv_bcd
);
   import rc_pkg::*;

   localparam int CNT_W = $clog2(CONV_BITS + 1);

   logic [CONV_BITS-1:0] bin_ff;
   logic [CONV_BITS-1:0] bin_in;
   logic [BCD_BITS-1:0]  bcd_ff;
   logic [BCD_BITS-1:0]  bcd_in;
   logic [BCD_BITS-1:0]  adj;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff;
   logic                 done_ff;

   // each digit of five or more gets three added before the shift
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end
      end
      bcd_in = {adj[BCD_BITS-2:0], bin_ff[CONV_BITS-1]};
      bin_in = {bin_ff[CONV_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (conv_go) begin
            bin_ff <= conv_value;
            bcd_ff <= '0;
            cnt_ff <= CNT_W'(CONV_BITS);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            bin_ff <= bin_in;
            bcd_ff <= bcd_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign conv_done = done_ff;
   assign conv_bcd  = bcd_ff;

endmodule

### design/radix_converter_checker.sv
// ----------------------------------------------------------------------------
// radix_converter_checker
// Port-level checks on the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
module radix_converter_checker (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input rc_pkg::req_type req_item,
   input logic            rsp_strobe,
   input rc_pkg::rsp_type rsp_item
);
   import rc_pkg::*;

   // reset leaves the block idle with no beat pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or beat after reset");

   // an error beat carries no digit and closes the request
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.error_code != ERR_NONE)
         |-> (rsp_item.last_digit_flag && rsp_item.digit_char == 7'd0))
      else $error("error beat not final or carries a digit");

   // a good beat is an upper-case hex or decimal digit
   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.error_code == ERR_NONE)
         |-> ((rsp_item.digit_char >= 7'd48 && rsp_item.digit_char <= 7'd57)
              || (rsp_item.digit_char >= 7'd65 && rsp_item.digit_char <= 7'd70)))
      else $error("digit beat out of range");

   // once digits start they come every cycle up to the last one
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last_digit_flag) |=> rsp_strobe)
      else $error("gap in digit beats");

   // a request with distinct radices keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.from_radix != req_item.to_radix) |=> busy)
      else $error("not busy after accepted request");

endmodule

bind radix_converter radix_converter_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
